// ===== rtl/kvl_pkg.sv =====
// Shared types and constants for the keyframe vector interpolation core.
// No dependencies; every module of the block imports this package.
package kvl_pkg;

  localparam int KVL_MAX_KEYS = 64;   // default keyframe table depth
  localparam int KCW          = 7;    // width of the key count register
  localparam int SLOT_W       = 6;
  localparam int TIME_W       = 24;   // unsigned Q16.8
  localparam int VAL_W        = 32;   // signed Q16.16
  localparam int FRAC_W       = 16;   // interpolation factor, Q0.16
  localparam int SEG_W        = 6;
  localparam int STATUS_W     = 2;
  localparam int S_TDATA_W    = 128;
  localparam int M_TDATA_W    = 104;

  // Operation carried in the input tuser bit.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSIDE = 2'd0,
    STATUS_BEFORE = 2'd1,
    STATUS_AFTER  = 2'd2
  } kvl_status_e;

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z
  } kvl_comp_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } kvl_state_e;

  // One keyframe as it sits in the table.
  typedef struct packed {
    logic signed [VAL_W-1:0] val_z;
    logic signed [VAL_W-1:0] val_y;
    logic signed [VAL_W-1:0] val_x;
    logic [TIME_W-1:0]       key_time;
  } kvl_key_t;

  localparam int KEY_W = $bits(kvl_key_t);

endpackage

// ===== rtl/kvl_key_mem.sv =====
// Keyframe table: one write port and one registered read port.
// Depends on kvl_pkg for the key record type.
module kvl_key_mem
  import kvl_pkg::*;
#(
  parameter int DEPTH = KVL_MAX_KEYS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  kvl_key_t      wdata_i,
  input  logic [AW-1:0] raddr_i,
  output kvl_key_t      rdata_o
);

  kvl_key_t mem_q [DEPTH];
  kvl_key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kvl_div.sv =====
// Restoring divider that produces a Q0.16 factor one quotient bit per cycle.
// The numerator must be below the denominator. Depends on kvl_pkg for widths.
module kvl_div
  import kvl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] num_i,
  input  logic [TIME_W-1:0] den_i,
  output logic              done_o,
  output logic [FRAC_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] rem_q, rem_d, den_q;
  logic [FRAC_W-1:0] quo_q;
  logic [TIME_W:0]   shifted;
  logic              fits;

  // Shift in a zero, then subtract the divisor when it fits.
  always_comb begin
    shifted = {rem_q, 1'b0};
    fits    = shifted >= {1'b0, den_q};
    rem_d   = fits ? TIME_W'(shifted - {1'b0, den_q}) : shifted[TIME_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FRAC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[FRAC_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/keyframe_vector_lerp_core.sv =====
// Keyframe table with linear interpolation of a 3-component vector.
// Uses kvl_pkg, kvl_key_mem (keyframe table) and kvl_div (factor divider).
//
// Usage: the slave stream carries load and query transactions, told apart by
// tuser. A load writes one keyframe (time and x/y/z) into the slot it names
// and produces no result; tready stays high. A query
// gives a time and produces one master transaction with the interpolated
// vector, the start key of the chosen segment and a status code.
// A query walks the table one key per cycle through the single read port of
// the keyframe memory until it finds the first key later than the query time,
// then runs a restoring division for the factor, then reuses one
// 33x17 multiplier and one saturating adder for x, y and z in turn.
// The key count is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while idle, and the core itself does not enforce this.
// tready is low while a query is in progress. The result sits in an output
// register, so the core returns to idle and accepts new transactions while a
// result waits; a stalled receiver only holds a finished query until the
// register frees. Reset sets the key count to one and clears all control
// state; the keyframe table is not cleared and must be loaded before use.
module keyframe_vector_lerp_core
  import kvl_pkg::*;
#(
  parameter int MAX_KEYS = KVL_MAX_KEYS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: key count, written when cfg_we_i is high.
  input  logic                 cfg_we_i,
  input  logic [KCW-1:0]       cfg_wdata_i,
  // Slave stream.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata from bit 0: key_slot(6), time_req(24), value_x(32), value_y(32),
  // value_z(32), two zero bits.
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: op (0 load, 1 query).
  input  logic                 s_axis_tuser_i,
  // Master stream.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // tdata from bit 0: out_x(32), out_y(32), out_z(32), segment(6), two zero bits.
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status (0 inside, 1 before first key, 2 at or after last key).
  output logic [STATUS_W-1:0]  m_axis_tuser_o
);

  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  // Count width holds both the 7-bit register and MAX_KEYS itself.
  localparam int CW = (IW + 1 > KCW) ? IW + 1 : KCW;

  // Input field unpacking.
  logic [SLOT_W-1:0] in_slot;
  logic [TIME_W-1:0] in_time;
  kvl_key_t          in_key;

  assign in_slot         = s_axis_tdata_i[5:0];
  assign in_time         = s_axis_tdata_i[29:6];
  assign in_key.key_time = in_time;
  assign in_key.val_x    = s_axis_tdata_i[61:30];
  assign in_key.val_y    = s_axis_tdata_i[93:62];
  assign in_key.val_z    = s_axis_tdata_i[125:94];

  kvl_state_e state_q, state_d;

  logic [KCW-1:0] key_count_q;
  logic [CW-1:0]  count_ext, n_keys;

  logic s_accept, m_accept;

  // Query context.
  logic [TIME_W-1:0] t_q, prev_q;
  logic [IW-1:0]     idx_q, seg_q, rd_addr;
  kvl_key_t          start_q, end_q, rd_key;
  logic [FRAC_W-1:0] factor_q;
  kvl_status_e       status_q;
  kvl_comp_e         comp_q;

  // Shared arithmetic.
  logic signed [VAL_W-1:0]           s_comp, e_comp;
  logic signed [VAL_W:0]             diff;
  logic signed [VAL_W+FRAC_W+1:0]    prod_q;
  logic signed [VAL_W+2:0]           sum;
  logic signed [VAL_W-1:0]           sat_val;
  logic signed [VAL_W-1:0]           res_q [3];

  // Divider and memory control.
  logic              found, seg_ok, last_key, div_start, div_done, mem_we;
  logic [FRAC_W-1:0] div_quot;

  // Output register.
  logic              m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic [STATUS_W-1:0]  m_user_q;
  logic              publish;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign m_accept = m_valid_q && m_axis_tready_i;

  // A count of zero acts as one, a count beyond the table as its depth.
  always_comb begin
    count_ext = CW'(key_count_q);
    if (count_ext == '0) begin
      n_keys = CW'(1);
    end else if (count_ext > CW'(MAX_KEYS)) begin
      n_keys = CW'(MAX_KEYS);
    end else begin
      n_keys = count_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KCW'(1);
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  // Scan decisions on the key read in this cycle.
  assign found    = t_q < rd_key.key_time;
  assign seg_ok   = (rd_key.key_time > prev_q) && (t_q >= prev_q);
  assign last_key = (CW'(idx_q) + CW'(1)) >= n_keys;

  kvl_key_mem #(
    .DEPTH(MAX_KEYS),
    .AW   (IW)
  ) u_key_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(IW'(in_slot)),
    .wdata_i(in_key),
    .raddr_i(rd_addr),
    .rdata_o(rd_key)
  );

  kvl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (t_q - prev_q),
    .den_i  (rd_key.key_time - prev_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && (s_axis_tuser_i == OP_QUERY)) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if ((n_keys == CW'(1)) || found) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_d = seg_ok ? ST_DIV : ST_MUL;
        end else if (last_key) begin
          state_d = ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (comp_q == COMP_Z) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_addr         = '0;
    div_start       = 1'b0;
    publish         = 1'b0;
    mem_we          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        mem_we = s_accept && (s_axis_tuser_i == OP_LOAD)
                 && (CW'(in_slot) < CW'(MAX_KEYS));
      end
      ST_FIRST: begin
        rd_addr = IW'(1);
      end
      ST_SCAN: begin
        rd_addr   = idx_q + IW'(1);
        div_start = found && seg_ok;
      end
      ST_DONE: begin
        publish = !m_valid_q || m_axis_tready_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      comp_q  <= COMP_X;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        comp_q <= COMP_X;
      end else if (state_q == ST_ADD) begin
        case (comp_q)
          COMP_X:  comp_q <= COMP_Y;
          COMP_Y:  comp_q <= COMP_Z;
          default: comp_q <= COMP_X;
        endcase
      end
    end
  end

  // Component selection for the shared multiply-add.
  function automatic logic signed [VAL_W-1:0] pick(kvl_key_t k, kvl_comp_e c);
    logic signed [VAL_W-1:0] v;
    case (c)
      COMP_X:  v = k.val_x;
      COMP_Y:  v = k.val_y;
      COMP_Z:  v = k.val_z;
      default: v = k.val_x;
    endcase
    return v;
  endfunction

  assign s_comp = pick(start_q, comp_q);
  assign e_comp = pick(end_q, comp_q);
  assign diff   = $signed({e_comp[VAL_W-1], e_comp}) - $signed({s_comp[VAL_W-1], s_comp});

  // The arithmetic shift of the product floors toward minus infinity.
  always_comb begin
    sum = $signed({{2{s_comp[VAL_W-1]}}, s_comp})
        + $signed(prod_q[VAL_W+FRAC_W+1:FRAC_W]);
    if (!sum[VAL_W+2] && (sum[VAL_W+1:VAL_W-1] != 3'b000)) begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum[VAL_W+2] && (sum[VAL_W+1:VAL_W-1] != 3'b111)) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = sum[VAL_W-1:0];
    end
  end

  // Query datapath. Clamped cases interpolate with a zero factor between
  // identical keys, so they share the same path.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          t_q <= in_time;
        end
      end
      ST_FIRST: begin
        start_q  <= rd_key;
        end_q    <= rd_key;
        prev_q   <= rd_key.key_time;
        idx_q    <= IW'(1);
        factor_q <= '0;
        seg_q    <= '0;
        if ((n_keys != CW'(1)) && found) begin
          status_q <= STATUS_BEFORE;
        end else begin
          status_q <= STATUS_INSIDE;
        end
      end
      ST_SCAN: begin
        if (found) begin
          end_q    <= rd_key;
          seg_q    <= idx_q - IW'(1);
          status_q <= STATUS_INSIDE;
        end else if (last_key) begin
          start_q  <= rd_key;
          end_q    <= rd_key;
          seg_q    <= idx_q - IW'(1);
          status_q <= STATUS_AFTER;
        end else begin
          start_q <= rd_key;
          prev_q  <= rd_key.key_time;
          idx_q   <= idx_q + IW'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          factor_q <= div_quot;
        end
      end
      ST_MUL: begin
        prod_q <= diff * $signed({1'b0, factor_q});
      end
      ST_ADD: begin
        res_q[comp_q] <= sat_val;
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished result waits here for the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (publish) begin
      m_valid_q <= 1'b1;
    end else if (m_accept) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (publish) begin
      m_data_q <= {2'b00, SEG_W'(seg_q), res_q[2], res_q[1], res_q[0]};
      m_user_q <= status_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule
